[hdl/snwg_pkg.sv]
// shared types and constants for the sum normalizer with gradient
// depends on nothing; used by the controller, the datapath and the top level
`default_nettype none

package snwg_pkg;

   // fixed-point fraction bits of the value format
   localparam int FRAC_BITS = 16;
   // width of the result index field
   localparam int IDX_WIDTH = 4;

   // operation codes carried on req_operation
   localparam logic OP_FORWARD  = 1'b0;
   localparam logic OP_BACKWARD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_END,
      ST_SQ,
      ST_RD,
      ST_PREP,
      ST_NUM,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic mul_act;
      logic acc_dot;
      logic finish;
      logic capture_sq;
      logic mul_grad;
      logic form_num;
      logic div_load;
      logic div_step;
      logic emit;
      logic next_elem;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic item_mul;
      logic last;
      logic err;
      logic div_done;
      logic out_free;
      logic elem_last;
   } status_type;

endpackage

`default_nettype wire

[hdl/snwg_ctrl.sv]
// controller state machine of the sum normalizer with gradient
// depends on snwg_pkg for the state, command and status types
`default_nettype none

module snwg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_ready,
   input  wire snwg_pkg::status_type status,
   output snwg_pkg::cmd_type        cmd
);

   snwg_pkg::state_type state_ff;
   snwg_pkg::state_type state_in;
   logic                accept;

   assign req_ready = (state_ff == snwg_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= snwg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         snwg_pkg::ST_IDLE: begin
            if (accept) begin
               if (status.item_mul) begin
                  state_in = snwg_pkg::ST_MUL;
               end else if (req_last) begin
                  state_in = snwg_pkg::ST_END;
               end
            end
         end
         snwg_pkg::ST_MUL: state_in = snwg_pkg::ST_ACC;
         snwg_pkg::ST_ACC: begin
            state_in = status.last ? snwg_pkg::ST_END : snwg_pkg::ST_IDLE;
         end
         snwg_pkg::ST_END: state_in = snwg_pkg::ST_SQ;
         snwg_pkg::ST_SQ: begin
            state_in = status.err ? snwg_pkg::ST_EMIT : snwg_pkg::ST_RD;
         end
         snwg_pkg::ST_RD:   state_in = snwg_pkg::ST_PREP;
         snwg_pkg::ST_PREP: state_in = snwg_pkg::ST_NUM;
         snwg_pkg::ST_NUM:  state_in = snwg_pkg::ST_LOAD;
         snwg_pkg::ST_LOAD: state_in = snwg_pkg::ST_DIV;
         snwg_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = snwg_pkg::ST_EMIT;
            end
         end
         snwg_pkg::ST_EMIT: begin
            if (status.out_free) begin
               if (status.elem_last) begin
                  state_in = snwg_pkg::ST_IDLE;
               end else if (!status.err) begin
                  state_in = snwg_pkg::ST_RD;
               end
            end
         end
         default: state_in = snwg_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         snwg_pkg::ST_IDLE: cmd.accept     = accept;
         snwg_pkg::ST_MUL:  cmd.mul_act    = 1'b1;
         snwg_pkg::ST_ACC:  cmd.acc_dot    = 1'b1;
         snwg_pkg::ST_END:  cmd.finish     = 1'b1;
         snwg_pkg::ST_SQ:   cmd.capture_sq = 1'b1;
         snwg_pkg::ST_PREP: cmd.mul_grad   = 1'b1;
         snwg_pkg::ST_NUM:  cmd.form_num   = 1'b1;
         snwg_pkg::ST_LOAD: cmd.div_load   = 1'b1;
         snwg_pkg::ST_DIV:  cmd.div_step   = !status.div_done;
         snwg_pkg::ST_EMIT: begin
            cmd.emit      = status.out_free;
            cmd.next_elem = status.out_free && !status.elem_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

[hdl/snwg_datapath.sv]
// datapath of the sum normalizer with gradient: element stores, sum and dot
// accumulators, shared multiplier, restoring divider and result register
// depends on snwg_pkg for the command and status types and constants
`default_nettype none

module snwg_datapath #(
   parameter int MAX_LEN     = 16,
   parameter int VALUE_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire snwg_pkg::cmd_type                   cmd,
   output snwg_pkg::status_type                     status,
   input  wire logic                                req_operation,
   input  wire logic signed [VALUE_WIDTH-1:0]       req_value,
   input  wire logic                                req_last,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [snwg_pkg::IDX_WIDTH-1:0]           rsp_index,
   output logic signed [VALUE_WIDTH-1:0]            rsp_result,
   output logic                                     rsp_final_res,
   output logic                                     rsp_error
);

   localparam int VW    = VALUE_WIDTH;
   localparam int AW    = $clog2(MAX_LEN);
   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int LW    = $clog2(MAX_LEN);
   localparam int SW    = VW + LW;
   localparam int DW    = 2 * VW + LW;
   localparam int NUMW  = DW + 1;
   localparam int DENW  = 2 * SW;
   localparam int QB    = VW + 2;
   localparam int SHW   = NUMW + snwg_pkg::FRAC_BITS + 1;
   localparam int DSW   = DENW + QB;
   localparam int CMPW  = ((SHW > DSW) ? SHW : DSW) + 1;
   localparam int STW   = $clog2(QB + 2);

   // element stores
   logic [VW-1:0] act_mem [MAX_LEN];
   logic [VW-1:0] grad_mem [MAX_LEN];
   logic [VW-1:0] act_rd_ff;
   logic [VW-1:0] grad_rd_ff;

   // run state
   logic            run_active_ff;
   logic            mode_ff;
   logic            last_ff;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   flen_ff;
   logic [CW-1:0]   n_ff;
   logic            fdone_ff;
   logic            err_ff;
   logic [SW-1:0]   sum_ff;
   logic [DW-1:0]   dot_ff;
   logic [VW-1:0]   gin_ff;
   logic [AW-1:0]   elem_ff;

   // arithmetic registers
   logic [DENW-1:0] prod_ff;
   logic [DENW-1:0] sq_ff;
   logic [NUMW-1:0] num_ff;
   logic [DENW-1:0] den_ff;
   logic [CMPW-1:0] rem_ff;
   logic [CMPW-1:0] dvs_ff;
   logic [QB:0]     quo_ff;
   logic [STW-1:0]  step_ff;
   logic            neg_ff;

   // result register
   logic            out_valid_ff;
   logic [AW-1:0]   out_idx_ff;
   logic [VW-1:0]   out_res_ff;
   logic            out_final_ff;
   logic            out_err_ff;

   // effective run context of the request on the input
   logic            eff_mode;
   logic [CW-1:0]   eff_count;
   logic [SW-1:0]   eff_sum;
   logic            dropped;
   logic [AW-1:0]   rd_addr;

   assign eff_mode  = run_active_ff ? mode_ff : req_operation;
   assign eff_count = run_active_ff ? count_ff : '0;
   assign eff_sum   = (!run_active_ff && req_operation == snwg_pkg::OP_FORWARD) ? '0 : sum_ff;
   assign dropped   = (eff_count >= CW'(MAX_LEN));
   assign rd_addr   = cmd.accept ? eff_count[AW-1:0] : elem_ff;

   // shared signed multiplier
   logic signed [SW-1:0]   mul_a;
   logic signed [SW-1:0]   mul_b;
   logic signed [DENW-1:0] mul_p;

   always_comb begin
      mul_a = $signed(sum_ff);
      mul_b = $signed(sum_ff);
      if (cmd.mul_act) begin
         mul_a = $signed({{LW{act_rd_ff[VW-1]}}, act_rd_ff});
         mul_b = $signed({{LW{gin_ff[VW-1]}}, gin_ff});
      end else if (cmd.mul_grad) begin
         mul_a = $signed({{LW{grad_rd_ff[VW-1]}}, grad_rd_ff});
      end
   end
   assign mul_p = mul_a * mul_b;

   // numerator forming
   logic [NUMW-1:0] act_ext;
   logic [NUMW-1:0] num_fwd;
   logic [NUMW-1:0] num_bwd;
   logic [NUMW-1:0] num_mag;
   logic [SW-1:0]   sum_mag;

   assign act_ext = {{(NUMW-VW){act_rd_ff[VW-1]}}, act_rd_ff};
   assign num_fwd = sum_ff[SW-1] ? (~act_ext + NUMW'(1)) : act_ext;
   assign num_bwd = {prod_ff[DW-1], prod_ff[DW-1:0]} - {dot_ff[DW-1], dot_ff};
   assign num_mag = num_ff[NUMW-1] ? (~num_ff + NUMW'(1)) : num_ff;
   assign sum_mag = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;

   // divider step and rounding
   logic            div_ge;
   logic [QB:0]     rnd_sum;
   logic [QB-1:0]   rnd;
   logic [QB-1:0]   lim;
   logic [QB-1:0]   mag_r;
   logic [VW-1:0]   res_val;

   assign div_ge  = (rem_ff >= dvs_ff);
   assign rnd_sum = {1'b0, quo_ff[QB-1:0]} + (QB+1)'(1);
   assign rnd     = rnd_sum[QB:1];
   assign lim     = {{(QB-VW+1){1'b0}}, {(VW-1){1'b1}}} + QB'(neg_ff);
   assign mag_r   = (quo_ff[QB] || rnd > lim) ? lim : rnd;
   assign res_val = neg_ff ? (~mag_r[VW-1:0] + VW'(1)) : mag_r[VW-1:0];

   // status to the controller
   assign status.item_mul  = (eff_mode == snwg_pkg::OP_BACKWARD) && !dropped;
   assign status.last      = last_ff;
   assign status.err       = err_ff;
   assign status.div_done  = (step_ff == STW'(QB + 1));
   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.elem_last = ((CW'(elem_ff) + CW'(1)) == n_ff);

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.accept && !dropped) begin
         if (eff_mode == snwg_pkg::OP_FORWARD) begin
            act_mem[eff_count[AW-1:0]] <= req_value;
         end else begin
            grad_mem[eff_count[AW-1:0]] <= req_value;
         end
      end
      act_rd_ff  <= act_mem[rd_addr];
      grad_rd_ff <= grad_mem[rd_addr];
   end

   // run control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         mode_ff       <= snwg_pkg::OP_FORWARD;
         count_ff      <= '0;
         flen_ff       <= '0;
         fdone_ff      <= 1'b0;
         sum_ff        <= '0;
         dot_ff        <= '0;
      end else begin
         if (cmd.accept) begin
            run_active_ff <= !req_last;
            mode_ff       <= eff_mode;
            count_ff      <= eff_count + CW'(!dropped);
            if (eff_mode == snwg_pkg::OP_FORWARD) begin
               if (!run_active_ff) begin
                  fdone_ff <= 1'b0;
               end
               sum_ff <= dropped ? eff_sum : eff_sum + {{LW{req_value[VW-1]}}, req_value};
            end else if (!run_active_ff) begin
               dot_ff <= '0;
            end
         end
         if (cmd.acc_dot) begin
            dot_ff <= dot_ff + prod_ff[DW-1:0];
         end
         if (cmd.finish && mode_ff == snwg_pkg::OP_FORWARD) begin
            flen_ff  <= count_ff;
            fdone_ff <= 1'b1;
         end
      end
   end

   // payload registers of the output phase
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         gin_ff  <= req_value;
         last_ff <= req_last;
      end
      if (cmd.mul_act || cmd.mul_grad || cmd.finish) begin
         prod_ff <= mul_p;
      end
      if (cmd.finish) begin
         n_ff    <= count_ff;
         elem_ff <= '0;
         if (mode_ff == snwg_pkg::OP_FORWARD) begin
            err_ff <= (sum_ff == '0);
         end else begin
            err_ff <= !fdone_ff || (sum_ff == '0) || (count_ff != flen_ff);
         end
      end
      if (cmd.capture_sq) begin
         sq_ff <= prod_ff;
      end
      if (cmd.next_elem) begin
         elem_ff <= elem_ff + AW'(1);
      end
      if (cmd.form_num) begin
         if (mode_ff == snwg_pkg::OP_FORWARD) begin
            num_ff <= num_fwd;
            den_ff <= {{(DENW-SW){1'b0}}, sum_mag};
         end else begin
            num_ff <= num_bwd;
            den_ff <= sq_ff;
         end
      end
      // restoring divider, overflow bit first then QB quotient bits
      if (cmd.div_load) begin
         rem_ff  <= {{(CMPW-NUMW){1'b0}}, num_mag} << (snwg_pkg::FRAC_BITS + 1);
         dvs_ff  <= {{(CMPW-DENW){1'b0}}, den_ff} << QB;
         quo_ff  <= '0;
         step_ff <= '0;
         neg_ff  <= num_ff[NUMW-1];
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         dvs_ff  <= dvs_ff >> 1;
         quo_ff  <= {quo_ff[QB-1:0], div_ge};
         step_ff <= step_ff + STW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_idx_ff   <= elem_ff;
         out_res_ff   <= err_ff ? '0 : res_val;
         out_final_ff <= status.elem_last;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = $signed(out_res_ff);
   assign rsp_final_res = out_final_ff;
   assign rsp_error     = out_err_ff;

   // index port is the low bits of the element position
   generate
      if (AW >= snwg_pkg::IDX_WIDTH) begin : g_idx_cut
         assign rsp_index = out_idx_ff[snwg_pkg::IDX_WIDTH-1:0];
      end else begin : g_idx_ext
         assign rsp_index = {{(snwg_pkg::IDX_WIDTH-AW){1'b0}}, out_idx_ff};
      end
   endgenerate

endmodule

`default_nettype wire

[hdl/sum_normalizer_with_gradient_unit.sv]
// top level of the sum normalizer with gradient
// depends on snwg_pkg, snwg_ctrl and snwg_datapath
`default_nettype none

// Vector sum normalization, forward and backward. Elements arrive one per
// request; a backward element also passes a multiply and an accumulate state,
// where the shared multiplier feeds the dot product, before the next request
// is taken. The request with last set ends the vector and starts the output
// phase, during which no request is taken. A forward run emits every element
// divided by the sum; a backward run emits grad_i/sum - dot(act,grad)/sum^2
// using the activations and sum of the last forward run. Each result comes
// from the restoring divider, which retires one quotient bit per cycle; error
// runs emit one zero result per cycle while the output is free. Results are
// rounded half away from zero and saturated to signed Q8.16.

module sum_normalizer_with_gradient_unit #(
   parameter int MAX_LEN     = 16,
   parameter int VALUE_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_operation,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [snwg_pkg::IDX_WIDTH-1:0]     rsp_index,
   output logic signed [VALUE_WIDTH-1:0]      rsp_result,
   output logic                               rsp_final_res,
   output logic                               rsp_error
);

   snwg_pkg::cmd_type    cmd;
   snwg_pkg::status_type status;

   snwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   snwg_datapath #(
      .MAX_LEN     (MAX_LEN),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_index     (rsp_index),
      .rsp_result    (rsp_result),
      .rsp_final_res (rsp_final_res),
      .rsp_error     (rsp_error)
   );

   // error results carry zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_result == '0)
      else $error("error result is not zero");

   // nothing is pending right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // no request is taken while a run still has results to produce
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> !req_ready)
      else $error("request taken in the middle of an output phase");

endmodule

`default_nettype wire
